// File: rtl/core/xpbd_pkg.sv
// Shared types, constants and helper functions for the XPBD distance solver.
// Used by the controller, the datapath and the top level; no dependencies.
package xpbd_pkg;

	localparam int VTX_AW = 10;
	localparam int EDGE_AW = 12;
	localparam int N_VTX = 1 << VTX_AW;
	localparam int N_EDGE = 1 << EDGE_AW;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	localparam logic [CFG_IW-1:0] REG_DT    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_INVDT = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ALPHA = 3'd2;
	localparam logic [CFG_IW-1:0] REG_GX    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_GY    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_GZ    = 3'd5;
	localparam logic [CFG_IW-1:0] REG_KEEP  = 3'd6;

	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_PREDICT = 3'd1;
	localparam logic [2:0] ACT_SOLVE   = 3'd2;
	localparam logic [2:0] ACT_INTEG   = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	localparam logic [16:0] RST_DT = 17'd1092;
	localparam logic [30:0] RST_INVDT = 31'd3932160;
	localparam logic signed [31:0] RST_GY = -32'sd642908;
	localparam logic [16:0] KEEP_ONE = 17'd65536;
	localparam logic [65:0] EPS_LEN2 = 66'd43;

	localparam logic [5:0] SQRT_STEPS = 6'd34;
	localparam logic [6:0] DIV_STEPS = 7'd64;
	localparam logic [1:0] LAST_AXIS = 2'd2;

	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] S32_MIN = 64'shffff_ffff_8000_0000;

	typedef enum logic [5:0] {
		ST_IDLE, ST_RDA, ST_CAPA, ST_CAPB, ST_LOAD, ST_PR_PREV, ST_PR_MG, ST_PR_AV,
		ST_PR_MV, ST_PR_AP, ST_WR_ALL, ST_IN_D, ST_IN_M1, ST_IN_A1, ST_IN_M2, ST_IN_A2,
		ST_SV_D, ST_SV_SQM, ST_SV_SQA, ST_SV_CHK, ST_SV_SQRT, ST_SV_AM, ST_SV_NUM,
		ST_SV_DINIT, ST_SV_DIV, ST_SV_DL, ST_SV_LW, ST_SV_SM, ST_SV_SDINIT, ST_SV_SDIV,
		ST_SV_SAP, ST_SV_WA, ST_SV_WB, ST_SV_SKIP, ST_DONE
	} ctrl_state_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_ACCEPT, OP_RDA, OP_CAPA, OP_CAPB, OP_LOAD, OP_PR_PREV, OP_MUL_G,
		OP_ADD_V, OP_MUL_V, OP_ADD_P, OP_WR_ALL, OP_IN_D, OP_MUL_I, OP_ADD_I, OP_MUL_K,
		OP_ADD_K, OP_SV_D, OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP,
		OP_ALPHA_MUL, OP_NUM, OP_DL_DIV_INIT, OP_DIV_STEP, OP_DL, OP_LAMW, OP_S_MUL,
		OP_S_DIV_INIT, OP_S_APPLY, OP_WR_PA, OP_WR_PB, OP_SKIP, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] act;
		logic pin_a;
		logic both_pinned;
		logic tiny;
		logic sq_last;
		logic div_last;
		logic out_block;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > S32_MAX) return S32_MAX[31:0];
		else if (x < S32_MIN) return S32_MIN[31:0];
		else return x[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		logic signed [31:0] n;
		n = -x;
		return x[31] ? n : x;
	endfunction

endpackage

// File: rtl/core/xpbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xpbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/xpbd_ctrl.sv
// Sequencer for the XPBD solver: walks each action through datapath commands.
// Depends on xpbd_pkg.
module xpbd_ctrl import xpbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_nxt;
	logic [1:0] axis_q;
	logic axis_end;

	assign axis_end = (axis_q == LAST_AXIS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 2'd0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_PR_AP, ST_IN_A2, ST_SV_SQA, ST_SV_SAP: begin
					axis_q <= axis_end ? 2'd0 : axis_q + 2'd1;
				end
				ST_IDLE: begin
					axis_q <= 2'd0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_RDA;
			ST_RDA: state_nxt = ST_CAPA;
			ST_CAPA: state_nxt = ST_CAPB;
			ST_CAPB: begin
				case (stat.act)
					ACT_LOAD: state_nxt = ST_LOAD;
					ACT_PREDICT: state_nxt = ST_PR_PREV;
					ACT_SOLVE: state_nxt = ST_SV_D;
					ACT_INTEG: state_nxt = ST_IN_D;
					ACT_READ: state_nxt = ST_DONE;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_LOAD: state_nxt = ST_DONE;
			ST_PR_PREV: state_nxt = stat.pin_a ? ST_WR_ALL : ST_PR_MG;
			ST_PR_MG: state_nxt = ST_PR_AV;
			ST_PR_AV: state_nxt = ST_PR_MV;
			ST_PR_MV: state_nxt = ST_PR_AP;
			ST_PR_AP: state_nxt = axis_end ? ST_WR_ALL : ST_PR_MG;
			ST_WR_ALL: state_nxt = ST_DONE;
			ST_IN_D: state_nxt = stat.pin_a ? ST_WR_ALL : ST_IN_M1;
			ST_IN_M1: state_nxt = ST_IN_A1;
			ST_IN_A1: state_nxt = ST_IN_M2;
			ST_IN_M2: state_nxt = ST_IN_A2;
			ST_IN_A2: state_nxt = axis_end ? ST_WR_ALL : ST_IN_M1;
			ST_SV_D: state_nxt = stat.both_pinned ? ST_SV_SKIP : ST_SV_SQM;
			ST_SV_SQM: state_nxt = ST_SV_SQA;
			ST_SV_SQA: state_nxt = axis_end ? ST_SV_CHK : ST_SV_SQM;
			ST_SV_CHK: state_nxt = stat.tiny ? ST_SV_SKIP : ST_SV_SQRT;
			ST_SV_SQRT: if (stat.sq_last) state_nxt = ST_SV_AM;
			ST_SV_AM: state_nxt = ST_SV_NUM;
			ST_SV_NUM: state_nxt = ST_SV_DINIT;
			ST_SV_DINIT: state_nxt = ST_SV_DIV;
			ST_SV_DIV: if (stat.div_last) state_nxt = ST_SV_DL;
			ST_SV_DL: state_nxt = ST_SV_LW;
			ST_SV_LW: state_nxt = ST_SV_SM;
			ST_SV_SM: state_nxt = ST_SV_SDINIT;
			ST_SV_SDINIT: state_nxt = ST_SV_SDIV;
			ST_SV_SDIV: if (stat.div_last) state_nxt = ST_SV_SAP;
			ST_SV_SAP: state_nxt = axis_end ? ST_SV_WA : ST_SV_SM;
			ST_SV_WA: state_nxt = ST_SV_WB;
			ST_SV_WB: state_nxt = ST_DONE;
			ST_SV_SKIP: state_nxt = ST_DONE;
			ST_DONE: if (!stat.out_block) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.axis = axis_q;
		cmd.op = OP_NONE;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
			ST_RDA: cmd.op = OP_RDA;
			ST_CAPA: cmd.op = OP_CAPA;
			ST_CAPB: cmd.op = OP_CAPB;
			ST_LOAD: cmd.op = OP_LOAD;
			ST_PR_PREV: cmd.op = OP_PR_PREV;
			ST_PR_MG: cmd.op = OP_MUL_G;
			ST_PR_AV: cmd.op = OP_ADD_V;
			ST_PR_MV: cmd.op = OP_MUL_V;
			ST_PR_AP: cmd.op = OP_ADD_P;
			ST_WR_ALL: cmd.op = OP_WR_ALL;
			ST_IN_D: cmd.op = OP_IN_D;
			ST_IN_M1: cmd.op = OP_MUL_I;
			ST_IN_A1: cmd.op = OP_ADD_I;
			ST_IN_M2: cmd.op = OP_MUL_K;
			ST_IN_A2: cmd.op = OP_ADD_K;
			ST_SV_D: cmd.op = OP_SV_D;
			ST_SV_SQM: cmd.op = OP_SQ_MUL;
			ST_SV_SQA: cmd.op = OP_SQ_ACC;
			ST_SV_CHK: cmd.op = OP_SQRT_INIT;
			ST_SV_SQRT: cmd.op = OP_SQRT_STEP;
			ST_SV_AM: cmd.op = OP_ALPHA_MUL;
			ST_SV_NUM: cmd.op = OP_NUM;
			ST_SV_DINIT: cmd.op = OP_DL_DIV_INIT;
			ST_SV_DIV: cmd.op = OP_DIV_STEP;
			ST_SV_DL: cmd.op = OP_DL;
			ST_SV_LW: cmd.op = OP_LAMW;
			ST_SV_SM: cmd.op = OP_S_MUL;
			ST_SV_SDINIT: cmd.op = OP_S_DIV_INIT;
			ST_SV_SDIV: cmd.op = OP_DIV_STEP;
			ST_SV_SAP: cmd.op = OP_S_APPLY;
			ST_SV_WA: cmd.op = OP_WR_PA;
			ST_SV_WB: cmd.op = OP_WR_PB;
			ST_SV_SKIP: cmd.op = OP_SKIP;
			ST_DONE: cmd.op = stat.out_block ? OP_NONE : OP_OUT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: rtl/core/xpbd_dp.sv
// Datapath: vertex and lambda stores, config registers, shared multiplier,
// iterative square root and divider, output register. Depends on xpbd_pkg, xpbd_ram.
module xpbd_dp import xpbd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	input  logic [2:0]                action,
	input  logic [VTX_AW-1:0]         vertex_a,
	input  logic [VTX_AW-1:0]         vertex_b,
	input  logic [EDGE_AW-1:0]        edge_index,
	input  logic [30:0]               rest_length,
	input  logic                      reset_lambda,
	input  logic signed [31:0]        load_x,
	input  logic signed [31:0]        load_y,
	input  logic signed [31:0]        load_z,
	input  logic                      pinned,
	input  logic                      cfg_we,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [CFG_DW-1:0]         cfg_data,
	output logic signed [31:0]        pos_x_out,
	output logic signed [31:0]        pos_y_out,
	output logic signed [31:0]        pos_z_out,
	output logic signed [31:0]        vel_x_out,
	output logic signed [31:0]        vel_y_out,
	output logic signed [31:0]        vel_z_out,
	output logic                      skipped,
	output logic                      out_valid,
	input  logic                      out_stall
);

	// config
	logic [16:0] dt_q, keep_q, keep_c;
	logic [30:0] invdt_q, alpha_q;
	logic signed [31:0] gx_q, gy_q, gz_q;

	// captured item
	logic [2:0] act_q;
	logic [VTX_AW-1:0] a_q, b_q;
	logic [EDGE_AW-1:0] e_q;
	logic [30:0] rest_q;
	logic rstl_q, pin_in_q;
	logic signed [31:0] load_q [3];

	// working registers
	logic signed [31:0] pos_a_q [3];
	logic signed [31:0] prev_a_q [3];
	logic signed [31:0] vel_a_q [3];
	logic signed [31:0] pos_b_q [3];
	logic pin_a_q, pin_b_q, skip_q;
	logic signed [31:0] lam_l_q, dl_q, tmp_q;
	logic [31:0] dmag_q [3];
	logic dneg_q [3];
	logic [65:0] len2_q;
	logic signed [49:0] num_q;
	logic [63:0] prod_q;
	logic psign_q;

	// square root and divider
	logic [67:0] sq_op_q;
	logic [35:0] sq_rem_q, sq_rem_nxt;
	logic [33:0] sq_root_q;
	logic [5:0] sq_cnt_q;
	logic [37:0] sq_trial_rem, sq_trial;
	logic sq_ge;
	logic [63:0] dv_dvd_q, dv_quo_q;
	logic [33:0] dv_rem_q, dv_dvs_q, dv_rem_nxt;
	logic [6:0] dv_cnt_q;
	logic [34:0] dv_trial;
	logic dv_ge;

	// combinational helpers
	logic [31:0] ma, mb;
	logic msg;
	logic [48:0] rnd_mag;
	logic signed [49:0] srnd;
	logic signed [63:0] srnd64;
	logic signed [32:0] diff [3];
	logic signed [31:0] diff_rhs [3];
	logic [1:0] wsum;
	logic [31:0] den;
	logic signed [49:0] nmag;
	logic signed [63:0] qv, sv;
	logic [1:0] k;
	logic out_valid_q;

	// RAM ports
	logic [VTX_AW-1:0] v_raddr, v_waddr;
	logic [95:0] pos_rd, prev_rd, vel_rd, pos_wd, prev_wd, vel_wd;
	logic pin_rd;
	logic pos_we, pv_we, pin_we, lam_we;
	logic [31:0] lam_rd, lam_wd;

	assign k = cmd.axis;
	assign keep_c = (keep_q > KEEP_ONE) ? KEEP_ONE : keep_q;

	always_comb begin
		ma = 32'd0;
		mb = 32'd0;
		msg = 1'b0;
		case (cmd.op)
			OP_MUL_G: begin
				ma = (k == 2'd0) ? abs32(gx_q) : (k == 2'd1) ? abs32(gy_q) : abs32(gz_q);
				mb = 32'(dt_q);
				msg = (k == 2'd0) ? gx_q[31] : (k == 2'd1) ? gy_q[31] : gz_q[31];
			end
			OP_MUL_V: begin
				ma = abs32(vel_a_q[k]);
				mb = 32'(dt_q);
				msg = vel_a_q[k][31];
			end
			OP_MUL_I: begin
				ma = dmag_q[k];
				mb = 32'(invdt_q);
				msg = dneg_q[k];
			end
			OP_MUL_K: begin
				ma = abs32(tmp_q);
				mb = 32'(keep_c);
				msg = tmp_q[31];
			end
			OP_SQ_MUL: begin
				ma = dmag_q[k];
				mb = dmag_q[k];
			end
			OP_ALPHA_MUL: begin
				ma = abs32(lam_l_q);
				mb = 32'(alpha_q);
				msg = lam_l_q[31];
			end
			OP_S_MUL: begin
				ma = abs32(dl_q);
				mb = dmag_q[k];
				msg = dl_q[31] ^ dneg_q[k];
			end
			default: ;
		endcase
	end

	always_comb begin
		rnd_mag = 49'((65'(prod_q) + 65'd32768) >> 16);
		srnd = psign_q ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
		srnd64 = 64'(srnd);
		for (int i = 0; i < 3; i++) begin
			diff_rhs[i] = (cmd.op == OP_SV_D) ? pos_b_q[i] : prev_a_q[i];
			diff[i] = 33'(pos_a_q[i]) - 33'(diff_rhs[i]);
		end
		wsum = 2'(!pin_a_q) + 2'(!pin_b_q);
		den = {14'd0, wsum, 16'd0} + 32'(alpha_q);
		nmag = num_q[49] ? -num_q : num_q;
		qv = $signed({16'd0, dv_quo_q[47:0]});
		sv = psign_q ? -$signed({32'd0, dv_quo_q[31:0]}) : $signed({32'd0, dv_quo_q[31:0]});

		sq_trial_rem = {sq_rem_q, sq_op_q[67:66]};
		sq_trial = {2'b00, sq_root_q, 2'b01};
		sq_ge = (sq_trial_rem >= sq_trial);
		sq_rem_nxt = sq_ge ? 36'(sq_trial_rem - sq_trial) : sq_trial_rem[35:0];

		dv_trial = {dv_rem_q, dv_dvd_q[63]};
		dv_ge = (dv_trial >= {1'b0, dv_dvs_q});
		dv_rem_nxt = dv_ge ? 34'(dv_trial - {1'b0, dv_dvs_q}) : dv_trial[33:0];
	end

	// control state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dt_q <= RST_DT;
			invdt_q <= RST_INVDT;
			alpha_q <= 31'd0;
			gx_q <= 32'sd0;
			gy_q <= RST_GY;
			gz_q <= 32'sd0;
			keep_q <= KEEP_ONE;
			sq_cnt_q <= 6'd0;
			dv_cnt_q <= 7'd0;
		end else begin
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DT: dt_q <= cfg_data[16:0];
					REG_INVDT: invdt_q <= cfg_data[30:0];
					REG_ALPHA: alpha_q <= cfg_data[30:0];
					REG_GX: gx_q <= cfg_data;
					REG_GY: gy_q <= cfg_data;
					REG_GZ: gz_q <= cfg_data;
					REG_KEEP: keep_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_SQRT_INIT) begin
				sq_cnt_q <= SQRT_STEPS;
			end else if (cmd.op == OP_SQRT_STEP) begin
				sq_cnt_q <= sq_cnt_q - 6'd1;
			end
			if (cmd.op == OP_DL_DIV_INIT || cmd.op == OP_S_DIV_INIT) begin
				dv_cnt_q <= DIV_STEPS;
			end else if (cmd.op == OP_DIV_STEP) begin
				dv_cnt_q <= dv_cnt_q - 7'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				act_q <= action;
				a_q <= vertex_a;
				b_q <= vertex_b;
				e_q <= edge_index;
				rest_q <= rest_length;
				rstl_q <= reset_lambda;
				load_q[0] <= load_x;
				load_q[1] <= load_y;
				load_q[2] <= load_z;
				pin_in_q <= pinned;
				skip_q <= 1'b0;
			end
			OP_CAPA: begin
				for (int i = 0; i < 3; i++) begin
					pos_a_q[i] <= pos_rd[32*i +: 32];
					prev_a_q[i] <= prev_rd[32*i +: 32];
					vel_a_q[i] <= vel_rd[32*i +: 32];
				end
				pin_a_q <= pin_rd;
				lam_l_q <= rstl_q ? 32'sd0 : lam_rd;
			end
			OP_CAPB: begin
				for (int i = 0; i < 3; i++) begin
					pos_b_q[i] <= pos_rd[32*i +: 32];
				end
				pin_b_q <= pin_rd;
			end
			OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					pos_a_q[i] <= load_q[i];
					vel_a_q[i] <= 32'sd0;
				end
			end
			OP_PR_PREV: begin
				for (int i = 0; i < 3; i++) begin
					prev_a_q[i] <= pos_a_q[i];
					if (pin_a_q) vel_a_q[i] <= 32'sd0;
				end
			end
			OP_ADD_V: vel_a_q[k] <= sat32(64'(vel_a_q[k]) + srnd64);
			OP_ADD_P: pos_a_q[k] <= sat32(64'(pos_a_q[k]) + srnd64);
			OP_IN_D, OP_SV_D: begin
				for (int i = 0; i < 3; i++) begin
					dneg_q[i] <= diff[i][32];
					dmag_q[i] <= diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
					// pinned vertex: restore position, stop motion
					if (cmd.op == OP_IN_D && pin_a_q) begin
						pos_a_q[i] <= prev_a_q[i];
						vel_a_q[i] <= 32'sd0;
					end
				end
				len2_q <= 66'd0;
			end
			OP_ADD_I: tmp_q <= sat32(srnd64);
			OP_ADD_K: vel_a_q[k] <= sat32(srnd64);
			OP_SQ_ACC: len2_q <= len2_q + 66'(prod_q);
			OP_SQRT_INIT: begin
				sq_op_q <= {2'b00, len2_q};
				sq_rem_q <= 36'd0;
				sq_root_q <= 34'd0;
			end
			OP_SQRT_STEP: begin
				sq_op_q <= {sq_op_q[65:0], 2'b00};
				sq_rem_q <= sq_rem_nxt;
				sq_root_q <= {sq_root_q[32:0], sq_ge};
			end
			OP_NUM: begin
				num_q <= 50'($signed({30'd0, sq_root_q}) - $signed({33'd0, rest_q}) + srnd64);
			end
			OP_DL_DIV_INIT: begin
				dv_dvd_q <= {nmag[47:0], 16'd0} + 64'(den >> 1);
				dv_dvs_q <= 34'(den);
				dv_rem_q <= 34'd0;
				dv_quo_q <= 64'd0;
			end
			OP_S_DIV_INIT: begin
				dv_dvd_q <= prod_q + 64'(sq_root_q >> 1);
				dv_dvs_q <= sq_root_q;
				dv_rem_q <= 34'd0;
				dv_quo_q <= 64'd0;
			end
			OP_DIV_STEP: begin
				dv_dvd_q <= {dv_dvd_q[62:0], 1'b0};
				dv_rem_q <= dv_rem_nxt;
				dv_quo_q <= {dv_quo_q[62:0], dv_ge};
			end
			OP_DL: dl_q <= sat32(num_q[49] ? qv : -qv);
			OP_S_APPLY: begin
				if (!pin_a_q) pos_a_q[k] <= sat32(64'(pos_a_q[k]) + sv);
				if (!pin_b_q) pos_b_q[k] <= sat32(64'(pos_b_q[k]) - sv);
			end
			OP_SKIP: skip_q <= 1'b1;
			OP_OUT: begin
				pos_x_out <= pos_a_q[0];
				pos_y_out <= pos_a_q[1];
				pos_z_out <= pos_a_q[2];
				vel_x_out <= vel_a_q[0];
				vel_y_out <= vel_a_q[1];
				vel_z_out <= vel_a_q[2];
				skipped <= skip_q;
			end
			default: ;
		endcase
		if (cmd.op == OP_MUL_G || cmd.op == OP_MUL_V || cmd.op == OP_MUL_I ||
				cmd.op == OP_MUL_K || cmd.op == OP_SQ_MUL || cmd.op == OP_ALPHA_MUL ||
				cmd.op == OP_S_MUL) begin
			prod_q <= 64'(ma) * 64'(mb);
			psign_q <= msg;
		end
	end

	// store ports
	always_comb begin
		v_raddr = (cmd.op == OP_CAPA) ? b_q : a_q;
		v_waddr = (cmd.op == OP_WR_PB) ? b_q : a_q;
		pos_we = (cmd.op == OP_LOAD) || (cmd.op == OP_WR_ALL) ||
			(cmd.op == OP_WR_PA) || (cmd.op == OP_WR_PB);
		pv_we = (cmd.op == OP_LOAD) || (cmd.op == OP_WR_ALL);
		pin_we = (cmd.op == OP_LOAD);
		lam_we = (cmd.op == OP_LAMW) || (cmd.op == OP_SKIP);
		lam_wd = (cmd.op == OP_SKIP) ? lam_l_q : sat32(64'(lam_l_q) + 64'(dl_q));
		case (cmd.op)
			OP_LOAD: pos_wd = {load_q[2], load_q[1], load_q[0]};
			OP_WR_PB: pos_wd = {pos_b_q[2], pos_b_q[1], pos_b_q[0]};
			default: pos_wd = {pos_a_q[2], pos_a_q[1], pos_a_q[0]};
		endcase
		prev_wd = (cmd.op == OP_LOAD) ? {load_q[2], load_q[1], load_q[0]}
			: {prev_a_q[2], prev_a_q[1], prev_a_q[0]};
		vel_wd = (cmd.op == OP_LOAD) ? 96'd0 : {vel_a_q[2], vel_a_q[1], vel_a_q[0]};
	end

	xpbd_ram #(.WIDTH(96), .DEPTH(N_VTX)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(v_waddr), .wdata(pos_wd),
		.raddr(v_raddr), .rdata(pos_rd)
	);

	xpbd_ram #(.WIDTH(96), .DEPTH(N_VTX)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(v_waddr), .wdata(prev_wd),
		.raddr(v_raddr), .rdata(prev_rd)
	);

	xpbd_ram #(.WIDTH(96), .DEPTH(N_VTX)) u_vel_ram (
		.clk(clk), .we(pv_we), .waddr(v_waddr), .wdata(vel_wd),
		.raddr(v_raddr), .rdata(vel_rd)
	);

	xpbd_ram #(.WIDTH(1), .DEPTH(N_VTX)) u_pin_ram (
		.clk(clk), .we(pin_we), .waddr(v_waddr), .wdata(pin_in_q),
		.raddr(v_raddr), .rdata(pin_rd)
	);

	xpbd_ram #(.WIDTH(32), .DEPTH(N_EDGE)) u_lam_ram (
		.clk(clk), .we(lam_we), .waddr(e_q), .wdata(lam_wd),
		.raddr(e_q), .rdata(lam_rd)
	);

	assign out_valid = out_valid_q;

	always_comb begin
		stat.act = act_q;
		stat.pin_a = pin_a_q;
		stat.both_pinned = pin_a_q & pin_b_q;
		stat.tiny = (len2_q < EPS_LEN2);
		stat.sq_last = (sq_cnt_q == 6'd1);
		stat.div_last = (dv_cnt_q == 7'd1);
		stat.out_block = out_valid_q & out_stall;
	end

endmodule

// File: rtl/core/xpbd_distance_constraint_solver_top.sv
// XPBD distance solver, one item at a time; stalling a waiting result holds back the next result.
// The result becomes valid in the same cycle that the next item can be taken.
// A solve is skipped when both vertices are pinned or the squared length is tiny;
// a full solve runs an iterative square root and four restoring divides.
// The next item is taken while a result still waits in the output register.
// Reset clears sequencer and output valid and sets config registers to defaults; stores hold garbage until written.
module xpbd_distance_constraint_solver_top import xpbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [VTX_AW-1:0]    vertex_a,
	input  logic [VTX_AW-1:0]    vertex_b,
	input  logic [EDGE_AW-1:0]   edge_index,
	input  logic [30:0]          rest_length,
	input  logic                 reset_lambda,
	input  logic signed [31:0]   load_x,
	input  logic signed [31:0]   load_y,
	input  logic signed [31:0]   load_z,
	input  logic                 pinned,
	input  logic                 cfg_we,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   pos_x_out,
	output logic signed [31:0]   pos_y_out,
	output logic signed [31:0]   pos_z_out,
	output logic signed [31:0]   vel_x_out,
	output logic signed [31:0]   vel_y_out,
	output logic signed [31:0]   vel_z_out,
	output logic                 skipped
);

	dp_cmd_t cmd;
	dp_stat_t stat;

	xpbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.stat(stat), .cmd(cmd)
	);

	xpbd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.edge_index(edge_index), .rest_length(rest_length),
		.reset_lambda(reset_lambda), .load_x(load_x), .load_y(load_y),
		.load_z(load_z), .pinned(pinned),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out), .pos_z_out(pos_z_out),
		.vel_x_out(vel_x_out), .vel_y_out(vel_y_out), .vel_z_out(vel_z_out),
		.skipped(skipped), .out_valid(out_valid), .out_stall(out_stall)
	);

endmodule
